/* hw/rtl/nfa_pkg.sv */
// Shared types, constants and the coefficient table of the nutation argument pipeline.
// No dependencies; every other file of the block imports this package.
package nfa_pkg;

	localparam int NUM_ARGS = 14;
	localparam int NUM_TERMS = 5;
	localparam int COEF_FRAC = 48;
	localparam int COEF_W = 64;
	localparam int TIME_W = 40;
	localparam int ANGLE_W = 54;
	localparam int IDX_W = 4;

	typedef logic [IDX_W-1:0] arg_idx_t;

	localparam arg_idx_t LAST_IDX = arg_idx_t'(NUM_ARGS - 1);

	// Control that travels with every argument through the pipeline.
	typedef struct packed {
		logic     valid;
		arg_idx_t idx;
	} nfa_tag_t;

	typedef enum int {
		UNIT_RAD  = 0,
		UNIT_DEG  = 1,
		UNIT_ASEC = 2,
		UNIT_PI   = 3
	} coef_unit_t;

	localparam logic [255:0] PI_126 = 256'hC90FDAA2_2168C234_C4C6628B_80DC1CD1;

	// Builds one coefficient n / 10^k in the given unit, as radians with 48 fraction bits,
	// rounded to nearest with ties away from zero. Evaluated at elaboration only.
	function automatic logic signed [COEF_W-1:0] mk_coef(input longint n, input int k,
			input coef_unit_t u);
		logic         neg;
		logic [255:0] mag;
		logic [255:0] x;
		neg = (n < 0);
		mag = neg ? 256'(-n) : 256'(n);
		if (u == UNIT_RAD) begin
			x = mag << 126;
		end else begin
			x = mag * PI_126;
		end
		x = x >> 77;
		for (int i = 0; i < k; i++) begin
			x = x / 10;
		end
		case (u)
			UNIT_DEG: x = x / 180;
			UNIT_ASEC: x = x / 648000;
			default: x = x;
		endcase
		x = (x + 256'd1) >> 1;
		return neg ? -$signed(x[COEF_W-1:0]) : $signed(x[COEF_W-1:0]);
	endfunction

	// Accumulator width for a given time format. The bound covers every Horner
	// intermediate for the full 40-bit time range with a few bits of margin.
	function automatic int acc_width(input int tfb);
		int ti;
		int g;
		ti = TIME_W - tfb - 1;
		g = 14;
		if (14 + ti > g) g = 14 + ti;
		if (2 * ti - 12 > g) g = 2 * ti - 12;
		if (3 * ti - 21 > g) g = 3 * ti - 21;
		if (4 * ti - 29 > g) g = 4 * ti - 29;
		return COEF_FRAC + g + 4;
	endfunction

	localparam logic signed [COEF_W-1:0] COEF [NUM_ARGS][NUM_TERMS] = '{
		'{mk_coef(64'sd13496340251, 8, UNIT_DEG), mk_coef(64'sd17179159232178, 4, UNIT_ASEC),
		  mk_coef(64'sd318792, 4, UNIT_ASEC), mk_coef(64'sd51635, 6, UNIT_ASEC),
		  mk_coef(-64'sd24470, 8, UNIT_ASEC)},
		'{mk_coef(64'sd35752910918, 8, UNIT_DEG), mk_coef(64'sd1295965810481, 4, UNIT_ASEC),
		  mk_coef(-64'sd5532, 4, UNIT_ASEC), mk_coef(64'sd136, 6, UNIT_ASEC),
		  mk_coef(-64'sd1149, 8, UNIT_ASEC)},
		'{mk_coef(64'sd9327209062, 8, UNIT_DEG), mk_coef(64'sd17395272628478, 4, UNIT_ASEC),
		  mk_coef(-64'sd127512, 4, UNIT_ASEC), mk_coef(-64'sd1037, 6, UNIT_ASEC),
		  mk_coef(64'sd417, 8, UNIT_ASEC)},
		'{mk_coef(64'sd29785019547, 8, UNIT_DEG), mk_coef(64'sd16029616012090, 4, UNIT_ASEC),
		  mk_coef(-64'sd63706, 4, UNIT_ASEC), mk_coef(64'sd6593, 6, UNIT_ASEC),
		  mk_coef(-64'sd3169, 8, UNIT_ASEC)},
		'{mk_coef(64'sd12504455501, 8, UNIT_DEG), mk_coef(-64'sd69628905431, 4, UNIT_ASEC),
		  mk_coef(64'sd74722, 4, UNIT_ASEC), mk_coef(64'sd7702, 6, UNIT_ASEC),
		  mk_coef(-64'sd5939, 8, UNIT_ASEC)},
		'{mk_coef(64'sd4402608842, 9, UNIT_RAD), mk_coef(64'sd26087903141574, 10, UNIT_RAD),
		  64'sd0, 64'sd0, 64'sd0},
		'{mk_coef(64'sd3176146697, 9, UNIT_RAD), mk_coef(64'sd10213285546211, 10, UNIT_RAD),
		  64'sd0, 64'sd0, 64'sd0},
		'{mk_coef(64'sd1753470314, 9, UNIT_RAD), mk_coef(64'sd6283075849991, 10, UNIT_RAD),
		  64'sd0, 64'sd0, 64'sd0},
		'{mk_coef(64'sd6203480913, 9, UNIT_RAD), mk_coef(64'sd3340612426700, 10, UNIT_RAD),
		  64'sd0, 64'sd0, 64'sd0},
		'{mk_coef(64'sd599546497, 9, UNIT_RAD), mk_coef(64'sd529690962641, 10, UNIT_RAD),
		  64'sd0, 64'sd0, 64'sd0},
		'{mk_coef(64'sd874016757, 9, UNIT_RAD), mk_coef(64'sd213299104960, 10, UNIT_RAD),
		  64'sd0, 64'sd0, 64'sd0},
		'{mk_coef(64'sd5481293872, 9, UNIT_RAD), mk_coef(64'sd74781598567, 10, UNIT_RAD),
		  64'sd0, 64'sd0, 64'sd0},
		'{mk_coef(64'sd5311886287, 9, UNIT_RAD), mk_coef(64'sd38133035638, 10, UNIT_RAD),
		  64'sd0, 64'sd0, 64'sd0},
		'{64'sd0, mk_coef(64'sd2438175, 8, UNIT_RAD), mk_coef(64'sd538691, 11, UNIT_RAD),
		  64'sd0, 64'sd0}
	};

	localparam logic [COEF_W-1:0] TWO_PI48 = mk_coef(64'sd2, 0, UNIT_PI);

endpackage

/* hw/rtl/nutation_fundamental_arguments.sv */
// Top level of the nutation fundamental argument generator.
// Instantiates nfa_seq, four nfa_horner steps and nfa_reduce; uses nfa_pkg.
//
// Usage:
// The input channel (in_valid, in_stall, time_centuries) takes one time value per beat.
// Each beat yields fourteen output beats (out_valid, out_stall, arg_index, angle_rad,
// last_arg) in index order 0 to 13, with last_arg high on index 13.
// Throughput: one argument leaves per cycle while out_stall allows it, so a new time value
// is taken only as the previous one issues its last argument; the sequencer sets this.
// Pipeline: each nfa_horner step has S = ceil(W / 32) accumulator slices and nfa_reduce
// has R = ceil((W - 50) / 4) reduction stages, for accumulator width W. At the default
// formats W is 73.
// cfg_wr_en with cfg_wr_data selects reduction into [0, 2 pi); write it only while idle.
// Reset clears the mode register, the sequencer and every valid bit.
// While out_stall is high with a beat waiting, the whole pipeline holds; the sequencer
// then stalls the input once it holds a time value.
module nutation_fundamental_arguments #(
	parameter int TIME_FRAC_BITS = 32,
	parameter int ANGLE_FRAC_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic                                cfg_wr_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [nfa_pkg::TIME_W-1:0]   time_centuries,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [nfa_pkg::IDX_W-1:0]           arg_index,
	output logic signed [nfa_pkg::ANGLE_W-1:0]  angle_rad,
	output logic                                last_arg
);
	import nfa_pkg::*;

	localparam int ACC_W = acc_width(TIME_FRAC_BITS);
	localparam int VW = ACC_W + 1;
	localparam int OUT_SHIFT = COEF_FRAC - ANGLE_FRAC_BITS;

	logic                    mode_q;
	logic                    adv;
	logic                    seq_busy;
	nfa_tag_t                tag_w [NUM_TERMS];
	logic [TIME_W-1:0]       t_w [NUM_TERMS];
	logic signed [ACC_W-1:0] acc_w [NUM_TERMS];
	nfa_tag_t                red_tag;
	logic signed [ACC_W-1:0] red_acc;
	logic [VW-1:0]           red_x;
	logic signed [VW-1:0]    sel_v;
	logic signed [VW-1:0]    sh_v;
	logic [VW-ANGLE_W:0]     top_bits;
	logic                    fits;
	logic [ANGLE_W-1:0]      angle_next;

	logic                    out_valid_q;
	arg_idx_t                arg_index_q;
	logic [ANGLE_W-1:0]      angle_q;
	logic                    last_arg_q;

	assign adv = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_wr_en) begin
			mode_q <= cfg_wr_data;
		end
	end

	nfa_seq #(.ACC_W(ACC_W)) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.time_centuries(time_centuries),
		.busy          (seq_busy),
		.tag_o         (tag_w[0]),
		.t_o           (t_w[0]),
		.acc_o         (acc_w[0])
	);

	for (genvar j = 0; j < NUM_TERMS - 1; j++) begin : g_step
		nfa_horner #(
			.TIME_FRAC_BITS(TIME_FRAC_BITS),
			.ACC_W         (ACC_W),
			.TERM          (NUM_TERMS - 2 - j)
		) u_step (
			.clk   (clk),
			.arst_n(arst_n),
			.adv   (adv),
			.tag_i (tag_w[j]),
			.t_i   (t_w[j]),
			.acc_i (acc_w[j]),
			.tag_o (tag_w[j+1]),
			.t_o   (t_w[j+1]),
			.acc_o (acc_w[j+1])
		);
	end

	nfa_reduce #(.ACC_W(ACC_W)) u_reduce (
		.clk   (clk),
		.arst_n(arst_n),
		.adv   (adv),
		.tag_i (tag_w[NUM_TERMS-1]),
		.acc_i (acc_w[NUM_TERMS-1]),
		.tag_o (red_tag),
		.acc_o (red_acc),
		.red_o (red_x)
	);

	// The reduced value is below two pi, so it is positive in VW signed bits.
	assign sel_v = mode_q ? $signed(red_x) : VW'(red_acc);
	assign sh_v = sel_v >>> OUT_SHIFT;
	assign top_bits = sh_v[VW-1:ANGLE_W-1];
	assign fits = (&top_bits) || !(|top_bits);

	always_comb begin
		if (fits) begin
			angle_next = sh_v[ANGLE_W-1:0];
		end else if (sh_v[VW-1]) begin
			angle_next = {1'b1, {(ANGLE_W-1){1'b0}}};
		end else begin
			angle_next = {1'b0, {(ANGLE_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= red_tag.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			arg_index_q <= red_tag.idx;
			angle_q <= angle_next;
			last_arg_q <= (red_tag.idx == LAST_IDX);
		end
	end

	assign out_valid = out_valid_q;
	assign arg_index = arg_index_q;
	assign angle_rad = $signed(angle_q);
	assign last_arg = last_arg_q;

	// Index that the next output beat must carry.
	arg_idx_t exp_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_idx_q <= '0;
		end else if (out_valid_q && !out_stall) begin
			exp_idx_q <= (exp_idx_q == LAST_IDX) ? '0 : exp_idx_q + 1'b1;
		end
	end

	a_index_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> arg_index_q == exp_idx_q)
		else $error("output argument index out of sequence");

	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && mode_q |-> !angle_q[ANGLE_W-1])
		else $error("reduced angle is negative");

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> seq_busy)
		else $error("input stalled while sequencer idle");

endmodule

/* hw/rtl/nfa_seq.sv */
// Input sequencer: holds one time value and issues its fourteen arguments, one per cycle while adv is high.
// Depends on nfa_pkg.
module nfa_seq #(
	parameter int ACC_W = 73
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [nfa_pkg::TIME_W-1:0]   time_centuries,
	output logic                         busy,
	output nfa_pkg::nfa_tag_t            tag_o,
	output logic [nfa_pkg::TIME_W-1:0]   t_o,
	output logic signed [ACC_W-1:0]      acc_o
);
	import nfa_pkg::*;

	logic                    busy_q;
	arg_idx_t                idx_q;
	logic [TIME_W-1:0]       t_q;
	nfa_tag_t                tag_s1;
	logic [TIME_W-1:0]       t_s1;
	logic signed [ACC_W-1:0] acc_s1;
	logic                    issue_last;
	logic                    take;

	assign issue_last = (idx_q == LAST_IDX);
	// A new beat is taken when idle, or in the cycle the last argument leaves.
	assign in_stall = busy_q && !(adv && issue_last);
	assign take = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
			tag_s1 <= '0;
		end else begin
			if (adv) begin
				tag_s1 <= '{valid: busy_q, idx: idx_q};
			end
			if (take) begin
				busy_q <= 1'b1;
				idx_q <= '0;
			end else if (adv && busy_q) begin
				if (issue_last) begin
					busy_q <= 1'b0;
					idx_q <= '0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			t_q <= time_centuries;
		end
		if (adv) begin
			t_s1 <= t_q;
			acc_s1 <= ACC_W'(COEF[idx_q][NUM_TERMS-1]);
		end
	end

	assign busy = busy_q;
	assign tag_o = tag_s1;
	assign t_o = t_s1;
	assign acc_o = acc_s1;

endmodule

/* hw/rtl/nfa_horner.sv */
// One Horner step, acc = c + floor(acc * t / 2^TIME_FRAC_BITS), as a multiply-accumulate
// chain over 32-bit slices of the accumulator followed by the coefficient add. Uses nfa_pkg.
module nfa_horner #(
	parameter int TIME_FRAC_BITS = 32,
	parameter int ACC_W = 73,
	parameter int TERM = 3
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  nfa_pkg::nfa_tag_t            tag_i,
	input  logic [nfa_pkg::TIME_W-1:0]   t_i,
	input  logic signed [ACC_W-1:0]      acc_i,
	output nfa_pkg::nfa_tag_t            tag_o,
	output logic [nfa_pkg::TIME_W-1:0]   t_o,
	output logic signed [ACC_W-1:0]      acc_o
);
	import nfa_pkg::*;

	localparam int NCH = (ACC_W + 31) / 32;
	localparam int PW = NCH * 32;
	localparam int SW = PW + TIME_W;
	localparam int PPW = 33 + TIME_W;

	nfa_tag_t             tag_s [NCH];
	logic [TIME_W-1:0]    t_s [NCH];
	logic signed [PW-1:0] accx_s [NCH];
	logic signed [SW-1:0] sum_s [NCH];

	nfa_tag_t                res_tag_s;
	logic [TIME_W-1:0]       res_t_s;
	logic signed [ACC_W-1:0] res_acc_s;
	logic signed [SW-1:0]    prod_sh;
	logic signed [ACC_W-1:0] acc_next;

	for (genvar i = 0; i < NCH; i++) begin : g_slice
		nfa_tag_t              tag_d;
		logic [TIME_W-1:0]     t_d;
		logic signed [PW-1:0]  accx_d;
		logic signed [SW-1:0]  sum_d;
		logic signed [PPW-1:0] pp;

		if (i == 0) begin : g_first
			assign tag_d = tag_i;
			assign t_d = t_i;
			assign accx_d = PW'(acc_i);
			assign sum_d = '0;
		end else begin : g_next
			assign tag_d = tag_s[i-1];
			assign t_d = t_s[i-1];
			assign accx_d = accx_s[i-1];
			assign sum_d = sum_s[i-1];
		end

		// Lower slices are unsigned magnitudes; only the top slice carries the sign.
		if (i == NCH - 1) begin : g_top
			assign pp = PPW'($signed(accx_d[32*i +: 32]) * $signed(t_d));
		end else begin : g_low
			assign pp = PPW'($signed({1'b0, accx_d[32*i +: 32]}) * $signed(t_d));
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[i] <= '0;
			end else if (adv) begin
				tag_s[i] <= tag_d;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				t_s[i] <= t_d;
				accx_s[i] <= accx_d;
				sum_s[i] <= sum_d + (SW'(pp) <<< (32 * i));
			end
		end
	end

	assign prod_sh = sum_s[NCH-1] >>> TIME_FRAC_BITS;
	assign acc_next = ACC_W'(COEF[tag_s[NCH-1].idx][TERM]) + prod_sh[ACC_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_tag_s <= '0;
		end else if (adv) begin
			res_tag_s <= tag_s[NCH-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_t_s <= t_s[NCH-1];
			res_acc_s <= acc_next;
		end
	end

	assign tag_o = res_tag_s;
	assign t_o = res_t_s;
	assign acc_o = res_acc_s;

endmodule

/* hw/rtl/nfa_reduce.sv */
// Floor reduction of the accumulator modulo two pi, by restoring subtraction of
// two pi times falling powers of two, four steps per stage. Uses nfa_pkg.
module nfa_reduce #(
	parameter int ACC_W = 73
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  nfa_pkg::nfa_tag_t         tag_i,
	input  logic signed [ACC_W-1:0]   acc_i,
	output nfa_pkg::nfa_tag_t         tag_o,
	output logic signed [ACC_W-1:0]   acc_o,
	output logic [ACC_W:0]            red_o
);
	import nfa_pkg::*;

	localparam int XW = ACC_W + 1;
	localparam int K = ACC_W - 51;
	localparam int NSTEP = K + 1;
	localparam int PER = 4;
	localparam int NST = (NSTEP + PER - 1) / PER;

	nfa_tag_t                tag_s [NST+1];
	logic signed [ACC_W-1:0] acc_s [NST+1];
	logic [XW-1:0]           x_s [NST+1];
	logic [XW-1:0]           x_first;

	// A negative value is lifted by two pi times 2^K, which keeps the remainder and
	// leaves a value below two pi times 2^(K+1).
	assign x_first = acc_i[ACC_W-1] ? (XW'(acc_i) + (XW'(TWO_PI48) << K)) : XW'(acc_i);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s[0] <= '0;
		end else if (adv) begin
			tag_s[0] <= tag_i;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			acc_s[0] <= acc_i;
			x_s[0] <= x_first;
		end
	end

	for (genvar s = 1; s <= NST; s++) begin : g_stage
		logic [XW-1:0] xr;

		always_comb begin
			xr = x_s[s-1];
			for (int q = 0; q < PER; q++) begin
				if (K - (s - 1) * PER - q >= 0) begin
					if (xr >= (XW'(TWO_PI48) << (K - (s - 1) * PER - q))) begin
						xr = xr - (XW'(TWO_PI48) << (K - (s - 1) * PER - q));
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[s] <= '0;
			end else if (adv) begin
				tag_s[s] <= tag_s[s-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				acc_s[s] <= acc_s[s-1];
				x_s[s] <= xr;
			end
		end
	end

	assign tag_o = tag_s[NST];
	assign acc_o = acc_s[NST];
	assign red_o = x_s[NST];

endmodule
